// ===== hdl/btff_pkg.sv =====
package btff_pkg;

  typedef struct packed {
    logic        cmd;
    logic [17:0] request_bytes;
    logic [17:0] user_offset;
  } btff_in_t;

  typedef struct packed {
    logic [17:0] result_offset;
    logic [1:0]  status;
    logic [18:0] heap_end_now;
  } btff_out_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;

  localparam logic CFG_SPLIT = 1'b0;
  localparam logic CFG_LARGE = 1'b1;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP_H,
    S_SETUP_F,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_GROW,
    S_GROW_F,
    S_FOUND,
    S_SPLIT_H2,
    S_SPLIT_F2,
    S_SPLIT_F1,
    S_ALLOC_RDF,
    S_ALLOC_H,
    S_ALLOC_F,
    S_FREE_RDH,
    S_FREE_HW,
    S_FREE_FRD,
    S_FREE_FW,
    S_FREE_NRD,
    S_FREE_NCHK,
    S_FREE_MH,
    S_FREE_MF,
    S_FREE_END,
    S_DONE
  } btff_state_t;

endpackage

// ===== hdl/boundary_tag_first_fit_allocator.sv =====
// Boundary-tag first-fit heap allocator. One command is taken while busy is
// low. Its single result appears for one cycle with done high and cannot be
// stalled. busy is already low in that cycle, so the next command can be taken
// at the edge that ends it. Every command runs a sequencer around one
// single-port word RAM with a registered read. Each command, step by step:
// - a free clears the allocated bit in the chunk's header and footer, then
//   checks the following chunk when there is one and merges it when free;
// - a rejected free or a too-large request goes straight to the result;
// - an allocate walks first-fit over the chunks from the lowest free one
//   until a free chunk is large enough;
// - the found chunk is split when its leftover exceeds the split threshold,
//   and the heap grows by whole pages when the walk finds no fit;
// - a refused growth ends after the walk with a no-space status.
// The first command after reset first writes the initial page's tags.
// Configuration writes are taken in any cycle and are meant only while the
// block is idle.
module boundary_tag_first_fit_allocator
  import btff_pkg::*;
#(
  parameter int HEAP_BYTES = 262144,
  parameter int PAGE_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  btff_in_t  in_item,
  output logic      done,
  output btff_out_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [18:0] cfg_data
);

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int WA    = $clog2(WORDS);
  localparam int AW    = $clog2(HEAP_BYTES) + 2;
  localparam int PGW   = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] PAGE  = AW'(PAGE_BYTES);
  localparam logic [AW-1:0] HEAPB = AW'(HEAP_BYTES);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata;
  logic        we;
  logic [AW-1:0] addr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr[WA+1:2]] <= wdata;
    rdata <= mem[addr[WA+1:2]];
  end

  btff_state_t state, state_next;
  logic [12:0] split_threshold;
  logic [18:0] large_limit;
  logic [AW-1:0] heap_end, heap_end_next;
  logic [AW-1:0] lowest_free, lowest_free_next;
  logic heap_ready, heap_ready_next;
  btff_in_t cur, cur_next;
  logic [AW-1:0] p, p_next, sz, sz_next, req, req_next, aux, aux_next;
  btff_out_t res, res_next;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      split_threshold <= 13'd16;
      large_limit <= 19'd131072;
      heap_end <= '0;
      lowest_free <= '0;
      heap_ready <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      heap_end <= heap_end_next;
      lowest_free <= lowest_free_next;
      heap_ready <= heap_ready_next;
      done <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPLIT: split_threshold <= cfg_data[12:0];
          CFG_LARGE: large_limit <= cfg_data;
          default: ;
        endcase
      end
    end
    cur <= cur_next;
    p <= p_next;
    sz <= sz_next;
    req <= req_next;
    aux <= aux_next;
    res <= res_next;
  end

  assign out_item = res;

  logic [AW-1:0] rsize;
  logic [AW-1:0] pages, grow, diff, uoff;
  assign rsize = AW'(rdata & SIZE_MASK);
  assign uoff  = AW'(cur.user_offset);

  always_comb begin
    state_next = state;
    heap_end_next = heap_end;
    lowest_free_next = lowest_free;
    heap_ready_next = heap_ready;
    cur_next = cur;
    p_next = p;
    sz_next = sz;
    req_next = req;
    aux_next = aux;
    res_next = res;
    we = 1'b0;
    addr = p;
    wdata = '0;
    pages = AW'(req >> PGW) + AW'(1);
    if (AW'(req[PGW-1:0]) < AW'(8)) pages = pages + AW'(1);
    grow = pages << PGW;
    diff = sz - req;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next = in_item;
          req_next = (AW'(in_item.request_bytes) + AW'(7)) & ~AW'(7);
          aux_next = '0;
          res_next = '0;
          state_next = heap_ready ? S_DISPATCH : S_SETUP_H;
        end
      end
      S_SETUP_H: begin
        we = 1'b1; addr = '0; wdata = 32'(PAGE - AW'(8));
        heap_ready_next = 1'b1;
        heap_end_next = PAGE;
        lowest_free_next = '0;
        state_next = S_SETUP_F;
      end
      S_SETUP_F: begin
        we = 1'b1; addr = PAGE - AW'(4); wdata = 32'(PAGE - AW'(8));
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (cur.cmd == CMD_ALLOC) begin
          if (19'(cur.request_bytes) >= large_limit) begin
            res_next.status = ST_TOO_BIG;
            state_next = S_DONE;
          end else begin
            p_next = lowest_free;
            state_next = S_WALK_RD;
          end
        end else begin
          p_next = uoff - AW'(4);
          if (uoff < AW'(4) || (uoff[2:0] != 3'd4) || (uoff - AW'(4)) >= heap_end)
            state_next = S_DONE;
          else state_next = S_FREE_RDH;
        end
      end
      S_WALK_RD: begin
        addr = p;
        state_next = (p < heap_end) ? S_WALK_CHK : S_GROW;
      end
      S_WALK_CHK: begin
        sz_next = rsize;
        if (!rdata[0] && rsize >= req) state_next = S_FOUND;
        else begin
          p_next = p + rsize + AW'(8);
          state_next = S_WALK_RD;
        end
      end
      S_GROW: begin
        if (heap_end + grow > HEAPB) begin
          res_next.status = ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          p_next = heap_end;
          sz_next = grow - AW'(8);
          heap_end_next = heap_end + grow;
          we = 1'b1; addr = heap_end; wdata = 32'(grow - AW'(8));
          state_next = S_GROW_F;
        end
      end
      S_GROW_F: begin
        we = 1'b1; addr = p + sz + AW'(4); wdata = 32'(sz);
        state_next = S_FOUND;
      end
      S_FOUND: begin
        if (diff > AW'(split_threshold)) begin
          we = 1'b1; addr = p; wdata = 32'(req);
          aux_next = diff - AW'(8);
          state_next = S_SPLIT_H2;
        end else state_next = S_ALLOC_RDF;
      end
      S_SPLIT_H2: begin
        we = 1'b1; addr = p + req + AW'(8); wdata = 32'(aux);
        state_next = S_SPLIT_F2;
      end
      S_SPLIT_F2: begin
        we = 1'b1; addr = p + req + AW'(12) + aux; wdata = 32'(aux);
        state_next = S_SPLIT_F1;
      end
      S_SPLIT_F1: begin
        we = 1'b1; addr = p + req + AW'(4); wdata = 32'(req);
        sz_next = req;
        state_next = S_ALLOC_RDF;
      end
      S_ALLOC_RDF: begin
        addr = p;
        state_next = S_ALLOC_H;
      end
      S_ALLOC_H: begin
        we = 1'b1; addr = p; wdata = rdata | 32'd1;
        sz_next = rsize;
        state_next = S_ALLOC_F;
      end
      S_ALLOC_F: begin
        addr = p + sz + AW'(4);
        if (aux == '1) begin
          we = 1'b1; wdata = rdata | 32'd1;
          res_next.result_offset = 18'(p + AW'(4));
          aux_next = '0;
          state_next = S_DONE;
        end else aux_next = '1;
      end
      S_FREE_RDH: begin
        addr = p;
        state_next = S_FREE_HW;
      end
      S_FREE_HW: begin
        we = 1'b1; addr = p; wdata = rdata & ~32'd1;
        sz_next = rsize;
        state_next = S_FREE_FRD;
      end
      S_FREE_FRD: begin
        addr = p + sz + AW'(4);
        state_next = S_FREE_FW;
      end
      S_FREE_FW: begin
        we = 1'b1; addr = p + sz + AW'(4); wdata = rdata & ~32'd1;
        aux_next = p + sz + AW'(8);
        state_next = (p + sz + AW'(8) < heap_end) ? S_FREE_NRD : S_FREE_END;
      end
      S_FREE_NRD: begin
        addr = aux;
        state_next = S_FREE_NCHK;
      end
      S_FREE_NCHK: begin
        if (!rdata[0]) begin
          sz_next = sz + rsize + AW'(8);
          state_next = S_FREE_MH;
        end else state_next = S_FREE_END;
      end
      S_FREE_MH: begin
        we = 1'b1; addr = p; wdata = 32'(sz);
        state_next = S_FREE_MF;
      end
      S_FREE_MF: begin
        we = 1'b1; addr = p + sz + AW'(4); wdata = 32'(sz);
        state_next = S_FREE_END;
      end
      S_FREE_END: begin
        if (p + sz + AW'(8) >= heap_end) heap_end_next = p;
        if (p < lowest_free) lowest_free_next = p;
        state_next = S_DONE;
      end
      S_DONE: begin
        res_next.heap_end_now = 19'(heap_end);
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DONE) res_next.heap_end_now = 19'(heap_end);
  end

  // Result heap end is latched when S_DONE is left; publish it on done.
  // done rises in the cycle after S_DONE, so res is already final.

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("command not taken");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.status == ST_OK || out_item.result_offset == '0))
    else $error("failed alloc with offset");

endmodule

// ===== sim/boundary_tag_first_fit_allocator_test.sv =====
`timescale 1ns / 100ps

module boundary_tag_first_fit_allocator_test;
  import btff_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint unsigned HEAP_SZ = 262144;
  localparam longint unsigned PAGE_SZ = 4096;
  localparam longint unsigned TAG_SZ = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  btff_in_t in_item = '0;
  logic done;
  btff_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_SPLIT;
  logic [18:0] cfg_data = '0;

  boundary_tag_first_fit_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the allocator: tag RAM, heap pointers and registers.
  bit [31:0] tag_ram [0:65535];
  longint unsigned shadow_end;
  longint unsigned shadow_low;
  bit shadow_ready;
  longint unsigned split_thr;
  longint unsigned large_lim;

  btff_out_t pending_results[$];
  int unsigned live_blocks[$];
  int errors = 0;
  int idle_cycles = 0;

  typedef struct {
    btff_in_t item;
    bit fixed;
    btff_out_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic bit [31:0] tag_rd(longint unsigned a);
    return tag_ram[(a >> 2) & 16'hFFFF];
  endfunction

  function automatic void tag_wr(longint unsigned a, bit [31:0] v);
    tag_ram[(a >> 2) & 16'hFFFF] = v;
  endfunction

  function automatic longint unsigned payload_len(longint unsigned p);
    return longint'(tag_rd(p) & SIZE_MASK);
  endfunction

  function automatic longint unsigned chunk_next(longint unsigned p);
    return p + payload_len(p) + 2 * TAG_SZ;
  endfunction

  function automatic void set_size(longint unsigned p, longint unsigned sz);
    tag_wr(p, sz[31:0]);
    tag_wr(p + sz + TAG_SZ, sz[31:0]);
  endfunction

  function automatic void set_alloc(longint unsigned p, bit on);
    longint unsigned f;
    bit [31:0] h;
    bit [31:0] t;
    f = p + payload_len(p) + TAG_SZ;
    h = tag_rd(p);
    t = tag_rd(f);
    h[0] = on;
    t[0] = on;
    tag_wr(p, h);
    tag_wr(f, t);
  endfunction

  function automatic btff_out_t heap_predict(btff_in_t it);
    btff_out_t r;
    longint unsigned size, p, nx, diff, pages, grow;
    bit found;
    r = '0;
    r.status = ST_OK;
    if (!shadow_ready) begin
      shadow_ready = 1'b1;
      shadow_end = PAGE_SZ;
      shadow_low = 0;
      set_size(0, PAGE_SZ - 2 * TAG_SZ);
    end
    if (it.cmd == CMD_ALLOC) begin
      size = (longint'(it.request_bytes) + 7) & ~64'd7;
      found = 1'b0;
      p = shadow_low;
      if (longint'(it.request_bytes) >= large_lim) begin
        r.status = ST_TOO_BIG;
      end else begin
        while (p < shadow_end) begin
          if ((tag_rd(p) & 32'd1) == 32'd0 && payload_len(p) >= size) begin
            found = 1'b1;
            break;
          end
          p = chunk_next(p);
        end
        if (!found) begin
          pages = size / PAGE_SZ + 1;
          if (size % PAGE_SZ < 2 * TAG_SZ) pages++;
          grow = pages * PAGE_SZ;
          if (shadow_end + grow > HEAP_SZ) begin
            r.status = ST_NO_SPACE;
          end else begin
            p = shadow_end;
            shadow_end = shadow_end + grow;
            set_size(p, grow - 2 * TAG_SZ);
            found = 1'b1;
          end
        end
        if (found) begin
          diff = payload_len(p) - size;
          if (diff > split_thr) begin
            set_size(p, size);
            set_size(chunk_next(p), diff - 2 * TAG_SZ);
          end
          set_alloc(p, 1'b1);
          r.result_offset = 18'(p + TAG_SZ);
        end
      end
    end else if (it.user_offset >= TAG_SZ) begin
      p = it.user_offset - TAG_SZ;
      if ((p & 7) == 0 && p < shadow_end) begin
        set_alloc(p, 1'b0);
        nx = chunk_next(p);
        if (nx < shadow_end && (tag_rd(nx) & 32'd1) == 32'd0)
          set_size(p, payload_len(p) + payload_len(nx) + 2 * TAG_SZ);
        if (chunk_next(p) >= shadow_end) shadow_end = p;
        if (p < shadow_low) shadow_low = p;
      end
    end
    r.heap_end_now = shadow_end[18:0];
    return r;
  endfunction

  // Keeps the list of live blocks so that the well-formed frees name real chunks.
  function automatic void track_live(btff_in_t it, btff_out_t r);
    if (it.cmd == CMD_ALLOC) begin
      if (r.status == ST_OK) live_blocks.push_back(32'(r.result_offset));
    end else begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == it.user_offset) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endfunction

  function automatic btff_in_t random_command();
    btff_in_t it;
    int unsigned r;
    int unsigned kind;
    int unsigned idx;
    it.request_bytes = 18'($urandom);
    it.user_offset = 18'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45 && live_blocks.size() > 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      it.cmd = CMD_FREE;
      it.user_offset = 18'(live_blocks[idx]);
    end else if (r < 53) begin
      // Malformed frees: the block must ignore every one of them.
      it.cmd = CMD_FREE;
      kind = $urandom_range(0, 2);
      if (kind == 0) begin
        it.user_offset = 18'($urandom_range(0, 3));
      end else if (kind == 1 || shadow_end + 12 > 18'h3FFFF) begin
        it.user_offset[2:0] = 3'($urandom_range(0, 6));
        if (it.user_offset[2:0] >= 3'd4) it.user_offset[2:0] = it.user_offset[2:0] + 3'd1;
      end else begin
        it.user_offset = 18'(shadow_end + TAG_SZ +
                             8 * $urandom_range(0, (18'h3FFFF - shadow_end - 4) / 8));
      end
    end else begin
      it.cmd = CMD_ALLOC;
      r = $urandom_range(0, 9);
      if (r < 7) it.request_bytes = 18'($urandom_range(0, 256));
      else if (r < 9) it.request_bytes = 18'($urandom_range(257, 6000));
    end
    return it;
  endfunction

  task automatic send_command(btff_in_t it, bit fixed, btff_out_t want, bit allow_idle);
    btff_out_t r;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    r = heap_predict(it);
    track_live(it, r);
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [18:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPLIT) split_thr = value & 19'h1FFF;
    else large_lim = value;
  endtask

  task automatic add_row(logic cmd, int unsigned req, int unsigned uoff, bit fixed,
                         int unsigned res, logic [1:0] st, int unsigned he);
    stim_row_t row;
    row.item.cmd = cmd;
    row.item.request_bytes = 18'(req);
    row.item.user_offset = 18'(uoff);
    row.fixed = fixed;
    row.want.result_offset = 18'(res);
    row.want.status = st;
    row.want.heap_end_now = 19'(he);
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_item);
        errors++;
      end else begin
        if (out_item.result_offset !== pending_results[0].result_offset) begin
          $display("%0t result_offset: expected %h actual %h", $time,
                   pending_results[0].result_offset, out_item.result_offset);
          errors++;
        end
        if (out_item.status !== pending_results[0].status) begin
          $display("%0t status: expected %h actual %h", $time,
                   pending_results[0].status, out_item.status);
          errors++;
        end
        if (out_item.heap_end_now !== pending_results[0].heap_end_now) begin
          $display("%0t heap_end_now: expected %h actual %h", $time,
                   pending_results[0].heap_end_now, out_item.heap_end_now);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Any cycle without a beat on some channel counts toward the watchdog.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_thr [6];
    int unsigned phase_large [6];
    int unsigned phase_items [6];
    btff_out_t none;
    none = '0;
    foreach (tag_ram[i]) tag_ram[i] = '0;
    shadow_end = 0;
    shadow_low = 0;
    shadow_ready = 1'b0;
    split_thr = 16;
    large_lim = 131072;

    // The first three allocations have fixed results; later ones are left to the
    // predictor. The ignored frees only report the heap end left by the grown 34-page chunk.
    add_row(CMD_ALLOC, 8, 0, 1, 4, ST_OK, 4096);
    add_row(CMD_ALLOC, 131072, 0, 1, 0, ST_TOO_BIG, 4096);
    add_row(CMD_ALLOC, 262143, 0, 1, 0, ST_TOO_BIG, 4096);
    add_row(CMD_ALLOC, 131071, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_FREE, 0, 3, 1, 0, ST_OK, 143360);
    add_row(CMD_FREE, 0, 6, 1, 0, ST_OK, 143360);
    add_row(CMD_FREE, 0, 262140, 1, 0, ST_OK, 143360);
    add_row(CMD_FREE, 262143, 262143, 1, 0, ST_OK, 143360);
    add_row(CMD_ALLOC, 130000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 131071, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 4084, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 4088, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 10, 0, 0, 0, ST_OK, 0);
    add_row(CMD_FREE, 0, 4100, 0, 0, ST_OK, 0);
    add_row(CMD_FREE, 0, 4, 0, 0, ST_OK, 0);
    add_row(CMD_FREE, 0, 4, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 1, 0, 0, 0, ST_OK, 0);

    phase_thr = '{0, 4096, 8191, 100, 16, 0};
    phase_large = '{262144, 524287, 262144, 0, 131072, 0};
    phase_items = '{80, 80, 80, 20, 80, 90};
    phase_thr[5] = $urandom_range(0, 8191);
    phase_large[5] = $urandom_range(2000, 524287);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_register(CFG_SPLIT, 19'(phase_thr[ph]));
      write_register(CFG_LARGE, 19'(phase_large[ph]));
      cfg_valid <= 1'b0;
      for (int n = 0; n < phase_items[ph]; n++)
        send_command(random_command(), 1'b0, none, ph < 5);
    end

    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
